FILE: sv/snshr_pkg.sv
// Shared types and constants for the selection name stack hit record engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package snshr_pkg;

    // Default depth of the name stack
    localparam int NAME_STACK_DEPTH_DEF = 32;

    // Field widths
    localparam int OP_W    = 3;
    localparam int WORD_W  = 32;
    localparam int HITS_W  = 16;
    localparam int CAP_W   = 16;

    // Reset value of the buffer capacity register
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd512;

    // Command codes
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP   = 3'd2;
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd3;
    localparam logic [OP_W-1:0] OP_HIT   = 3'd4;
    localparam logic [OP_W-1:0] OP_MODE  = 3'd5;

    // Which word the output register takes
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_COUNT,
        EMIT_MIN,
        EMIT_MAX,
        EMIT_NAME,
        EMIT_FLAG,
        EMIT_REPLY
    } emit_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      in_ready;   // take a new item
        logic      decode;     // evaluate the latched command
        emit_sel_t emit;       // load the output register
        logic      emit_last;  // mark the loaded item as the final one
        logic      name_read;  // read the name stack at the walk index
        logic      apply;      // commit stack and mode changes
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            rec_emit;   // a record fits and goes out
        logic            flag_need;  // overflow or stack error raised
        logic            name_last;  // walk index is at the top name
        logic            slot_free;  // output register can take an item
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/snshr_datapath.sv
// Datapath of the selection name stack hit record engine: state registers,
// name stack memory, record checks and the output register. Uses snshr_pkg.
`default_nettype none

module snshr_datapath #(
    parameter int NAME_STACK_DEPTH = snshr_pkg::NAME_STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [snshr_pkg::CAP_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    input  wire logic [snshr_pkg::OP_W-1:0]    in_op,
    input  wire logic [snshr_pkg::WORD_W-1:0]  in_name,
    input  wire logic [snshr_pkg::WORD_W-1:0]  in_zmin,
    input  wire logic [snshr_pkg::WORD_W-1:0]  in_zmax,
    input  wire logic                          in_mode,
    input  wire snshr_pkg::dp_cmd_t            cmd,
    output snshr_pkg::dp_status_t              status,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic                               out_kind,
    output logic                               out_last,
    output logic [snshr_pkg::WORD_W-1:0]       out_word,
    output logic [snshr_pkg::HITS_W-1:0]       out_prev,
    output logic                               out_ovf,
    output logic                               out_serr
);

    localparam int CNT_W  = $clog2(NAME_STACK_DEPTH + 1);
    localparam int ADDR_W = (NAME_STACK_DEPTH > 1) ? $clog2(NAME_STACK_DEPTH) : 1;
    localparam int SUM_W  = snshr_pkg::CAP_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(NAME_STACK_DEPTH);

    // Latched command
    logic [snshr_pkg::OP_W-1:0]   op_reg;
    logic [snshr_pkg::WORD_W-1:0] name_reg;
    logic [snshr_pkg::WORD_W-1:0] zmin_reg;
    logic [snshr_pkg::WORD_W-1:0] zmax_reg;
    logic                         mode_reg;

    // Engine state
    logic [CNT_W-1:0]              count_reg;
    logic                          selecting_reg;
    logic                          pending_reg;
    logic [snshr_pkg::WORD_W-1:0]  least_reg;
    logic [snshr_pkg::WORD_W-1:0]  greatest_reg;
    logic [snshr_pkg::CAP_W-1:0]   wpos_reg;
    logic [snshr_pkg::HITS_W-1:0]  hits_reg;
    logic [snshr_pkg::CAP_W-1:0]   cap_reg;

    // Per-command flags and name walk
    logic                          ovf_reg;
    logic                          serr_reg;
    logic                          flush_reg;
    logic [CNT_W-1:0]              idx_reg;

    // Name stack memory
    logic [snshr_pkg::WORD_W-1:0]  stack_mem [NAME_STACK_DEPTH];
    logic [snshr_pkg::WORD_W-1:0]  rd_data_reg;

    // Output register
    logic                          valid_reg;
    logic                          kind_reg;
    logic                          last_reg;
    logic [snshr_pkg::WORD_W-1:0]  word_reg;
    logic [snshr_pkg::HITS_W-1:0]  prev_reg;
    logic                          oovf_reg;
    logic                          oserr_reg;

    logic                          flush_c;
    logic                          has_rec_c;
    logic [SUM_W-1:0]              end_pos_c;
    logic                          fit_fail_c;
    logic                          rec_emit_c;
    logic                          ovf_c;
    logic                          serr_c;
    logic                          slot_free;

    // Decide flush, fit and stack misuse for the latched command
    always_comb
    begin
        flush_c    = selecting_reg && ((op_reg == snshr_pkg::OP_CLEAR) ||
                                       (op_reg == snshr_pkg::OP_LOAD)  ||
                                       (op_reg == snshr_pkg::OP_POP)   ||
                                       (op_reg == snshr_pkg::OP_PUSH)  ||
                                       (op_reg == snshr_pkg::OP_MODE));
        has_rec_c  = flush_c && (count_reg != '0) && pending_reg;
        end_pos_c  = {1'b0, wpos_reg} + SUM_W'(count_reg) + SUM_W'(3);
        fit_fail_c = end_pos_c > {1'b0, cap_reg};
        rec_emit_c = has_rec_c && !fit_fail_c;
        ovf_c      = has_rec_c && fit_fail_c;
        serr_c     = selecting_reg &&
                     ((((op_reg == snshr_pkg::OP_LOAD) || (op_reg == snshr_pkg::OP_POP)) &&
                       (count_reg == '0)) ||
                      ((op_reg == snshr_pkg::OP_PUSH) && (count_reg >= DEPTH_CNT)));
        slot_free  = !valid_reg || out_ready;
    end

    assign status.op        = op_reg;
    assign status.rec_emit  = rec_emit_c;
    assign status.flag_need = ovf_c || serr_c;
    assign status.name_last = (idx_reg == (count_reg - CNT_W'(1)));
    assign status.slot_free = slot_free;

    // Hold the accepted command
    always_ff @(posedge clk)
    begin
        if (in_valid && cmd.in_ready)
        begin
            op_reg   <= in_op;
            name_reg <= in_name;
            zmin_reg <= in_zmin;
            zmax_reg <= in_zmax;
            mode_reg <= in_mode;
        end
    end

    // Write and read the name stack
    always_ff @(posedge clk)
    begin
        if (cmd.apply && selecting_reg && !serr_reg)
        begin
            if (op_reg == snshr_pkg::OP_LOAD)
            begin
                stack_mem[ADDR_W'(count_reg - CNT_W'(1))] <= name_reg;
            end
            else if (op_reg == snshr_pkg::OP_PUSH)
            begin
                stack_mem[ADDR_W'(count_reg)] <= name_reg;
            end
        end
        if (cmd.name_read)
        begin
            rd_data_reg <= stack_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // Engine state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            selecting_reg <= 1'b0;
            pending_reg   <= 1'b0;
            least_reg     <= '1;
            greatest_reg  <= '0;
            wpos_reg      <= '0;
            hits_reg      <= '0;
            cap_reg       <= snshr_pkg::CAPACITY_RESET;
            ovf_reg       <= 1'b0;
            serr_reg      <= 1'b0;
            flush_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end

            if (cmd.decode)
            begin
                ovf_reg   <= ovf_c;
                serr_reg  <= serr_c;
                flush_reg <= flush_c;
                idx_reg   <= '0;
                // Count the record that goes out
                if (rec_emit_c)
                begin
                    wpos_reg <= end_pos_c[snshr_pkg::CAP_W-1:0];
                    if (hits_reg != '1)
                    begin
                        hits_reg <= hits_reg + snshr_pkg::HITS_W'(1);
                    end
                end
                // Widen the pending depth range
                if (op_reg == snshr_pkg::OP_HIT)
                begin
                    if (least_reg > zmin_reg)
                    begin
                        least_reg <= zmin_reg;
                    end
                    if (greatest_reg < zmax_reg)
                    begin
                        greatest_reg <= zmax_reg;
                    end
                    pending_reg <= 1'b1;
                end
            end

            // Advance the name walk
            if (cmd.emit == snshr_pkg::EMIT_NAME)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.apply)
            begin
                if (flush_reg)
                begin
                    pending_reg  <= 1'b0;
                    least_reg    <= '1;
                    greatest_reg <= '0;
                end
                case (op_reg)
                    snshr_pkg::OP_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    snshr_pkg::OP_POP:
                    begin
                        if (selecting_reg && !serr_reg)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                        end
                    end
                    snshr_pkg::OP_PUSH:
                    begin
                        if (selecting_reg && !serr_reg)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    snshr_pkg::OP_MODE:
                    begin
                        selecting_reg <= mode_reg;
                        wpos_reg      <= '0;
                        hits_reg      <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit != snshr_pkg::EMIT_NONE)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit != snshr_pkg::EMIT_NONE)
        begin
            kind_reg  <= (cmd.emit == snshr_pkg::EMIT_REPLY);
            last_reg  <= cmd.emit_last;
            oovf_reg  <= ovf_reg;
            oserr_reg <= serr_reg;
            prev_reg  <= (cmd.emit == snshr_pkg::EMIT_REPLY) ? hits_reg : '0;
            case (cmd.emit)
                snshr_pkg::EMIT_COUNT: word_reg <= snshr_pkg::WORD_W'(count_reg);
                snshr_pkg::EMIT_MIN:   word_reg <= least_reg;
                snshr_pkg::EMIT_MAX:   word_reg <= greatest_reg;
                snshr_pkg::EMIT_NAME:  word_reg <= rd_data_reg;
                default:               word_reg <= '0;
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_word  = word_reg;
    assign out_prev  = prev_reg;
    assign out_ovf   = oovf_reg;
    assign out_serr  = oserr_reg;

endmodule

`default_nettype wire

FILE: sv/snshr_ctrl.sv
// Controller of the selection name stack hit record engine: sequences decode,
// record emission, replies and commit. Uses snshr_pkg types.
`default_nettype none

module snshr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire snshr_pkg::dp_status_t status,
    output snshr_pkg::dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_COUNT,
        S_MIN,
        S_MAX,
        S_READ,
        S_NAME,
        S_FLAG,
        S_REPLY,
        S_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_mode;

    assign is_mode = (status.op == snshr_pkg::OP_MODE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.in_ready  = 1'b0;
        cmd.decode    = 1'b0;
        cmd.emit      = snshr_pkg::EMIT_NONE;
        cmd.emit_last = 1'b0;
        cmd.name_read = 1'b0;
        cmd.apply     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (status.op == snshr_pkg::OP_HIT)
                begin
                    state_next = S_IDLE;
                end
                else if (status.rec_emit)
                begin
                    state_next = S_COUNT;
                end
                else if (is_mode)
                begin
                    state_next = S_REPLY;
                end
                else if (status.flag_need)
                begin
                    state_next = S_FLAG;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_COUNT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = snshr_pkg::EMIT_COUNT;
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = snshr_pkg::EMIT_MIN;
                    state_next = S_MAX;
                end
            end
            S_MAX:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = snshr_pkg::EMIT_MAX;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.name_read = 1'b1;
                state_next    = S_NAME;
            end
            S_NAME:
            begin
                if (status.slot_free)
                begin
                    cmd.emit      = snshr_pkg::EMIT_NAME;
                    cmd.emit_last = status.name_last && !is_mode;
                    if (!status.name_last)
                    begin
                        state_next = S_READ;
                    end
                    else if (is_mode)
                    begin
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_FLAG:
            begin
                if (status.slot_free)
                begin
                    cmd.emit      = snshr_pkg::EMIT_FLAG;
                    cmd.emit_last = 1'b1;
                    state_next    = S_APPLY;
                end
            end
            S_REPLY:
            begin
                if (status.slot_free)
                begin
                    cmd.emit      = snshr_pkg::EMIT_REPLY;
                    cmd.emit_last = 1'b1;
                    state_next    = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/selection_name_stack_hit_records_top.sv
// Top level of the selection name stack hit record engine.
// Instantiates snshr_ctrl and snshr_datapath; uses snshr_pkg.
`default_nettype none

// Takes one command item at a time and returns hit record words and set-mode
// replies on the master stream; tlast marks the final item of each command
// that returns items. A register-hit command returns no item; clear, load, pop
// and push with no record return none, or one overflow or stack error flag
// item; a command that flushes a record of N names returns its words subject
// to any output stall, and a set-mode command adds its reply. The rate is set
// by the controller sequence and by the name stack memory, whose registered
// read port is read before each name goes out.
// cfg_data writes the buffer capacity in words whenever cfg_we is high.
module selection_name_stack_hit_records_top #(
    parameter int NAME_STACK_DEPTH = snshr_pkg::NAME_STACK_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // Configuration: buffer capacity
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_data,
    // Command stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [103:0]  s_axis_tdata,  // name_value, hit_min_depth, hit_max_depth, mode_on
    input  wire logic [2:0]    s_axis_tuser,  // op
    // Result stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [55:0]        m_axis_tdata,  // record_word, previous_hits, overflow, stack_error
    output logic [0:0]         m_axis_tuser,  // kind
    output logic               m_axis_tlast
);

    snshr_pkg::dp_cmd_t    cmd;
    snshr_pkg::dp_status_t status;

    logic                          out_kind;
    logic [snshr_pkg::WORD_W-1:0]  out_word;
    logic [snshr_pkg::HITS_W-1:0]  out_prev;
    logic                          out_ovf;
    logic                          out_serr;

    snshr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    snshr_datapath #(
        .NAME_STACK_DEPTH (NAME_STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_name   (s_axis_tdata[31:0]),
        .in_zmin   (s_axis_tdata[63:32]),
        .in_zmax   (s_axis_tdata[95:64]),
        .in_mode   (s_axis_tdata[96]),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (out_kind),
        .out_last  (m_axis_tlast),
        .out_word  (out_word),
        .out_prev  (out_prev),
        .out_ovf   (out_ovf),
        .out_serr  (out_serr)
    );

    // Pack the result item
    assign s_axis_tready   = cmd.in_ready;
    assign m_axis_tuser[0] = out_kind;
    assign m_axis_tdata    = {6'd0, out_serr, out_ovf, out_prev, out_word};

endmodule

`default_nettype wire
